// ===== hdl/rlbt_pkg.sv =====
package rlbt_pkg;

    // Field widths fixed by the register map and the item format.
    localparam int LVL_W      = 7;
    localparam int BRIGHT_W   = 7;
    localparam int COLOR_W    = 12;
    localparam int MODE_W     = 2;
    localparam int PERIOD_W   = 12;
    localparam int DUTY_W     = 7;
    localparam int LATENCY_W  = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int MS_W       = 10;
    localparam int COLOR_PROD_W = 11;
    localparam int DUTY_PROD_W  = 19;

    typedef logic [LVL_W-1:0]         t_level;
    typedef logic [2:0][LVL_W-1:0]    t_levels;  // 0 green, 1 red, 2 blue
    typedef logic [PERIOD_W-1:0]      t_phase_time;

    // Register indexes on the configuration channel.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BRIGHTNESS = 3'd0,
        CFG_COLOR      = 3'd1,
        CFG_MODE       = 3'd2,
        CFG_PERIOD     = 3'd3,
        CFG_DUTY       = 3'd4,
        CFG_LATENCY    = 3'd5
    } t_cfg_idx;

    // Blink modes; every mode other than blink only holds the outputs.
    localparam logic [MODE_W-1:0] MODE_BLINK = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TABLE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HOLD  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    localparam t_level  LVL_DARK     = 7'd100;
    localparam t_levels LEVELS_DARK  = {3{LVL_DARK}};
    localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;
    localparam logic [MS_W-1:0]   MS_LAST   = 10'd999;

    // Reset values of the registers.
    localparam logic [BRIGHT_W-1:0]  RST_BRIGHTNESS = 7'd30;
    localparam logic [COLOR_W-1:0]   RST_COLOR      = 12'd4095;
    localparam logic [MODE_W-1:0]    RST_MODE       = 2'd0;
    localparam logic [PERIOD_W-1:0]  RST_PERIOD     = 12'd500;
    localparam logic [DUTY_W-1:0]    RST_DUTY       = 7'd30;
    localparam logic [LATENCY_W-1:0] RST_LATENCY    = 6'd1;

    // Cycles the derived-value pipeline needs after a register write.
    localparam logic [1:0] SETTLE_CYCLES = 2'd2;

    // Reciprocal constants: floor(x/15) for x < 2^11, floor(x/100) for x < 2^19.
    localparam int DIV15_MUL    = 2185;
    localparam int DIV15_SHIFT  = 15;
    localparam int DIV100_MUL   = 671089;
    localparam int DIV100_SHIFT = 26;

    // Active-low level from nibble*brightness: 100 - prod/15, floored at 0.
    function automatic t_level lvl_from_prod(input logic [COLOR_PROD_W-1:0] prod);
        logic [22:0] scaled;
        logic [7:0]  quot;
        scaled = 23'(prod) * 23'(DIV15_MUL);
        quot   = 8'(scaled >> DIV15_SHIFT);
        if (quot >= 8'(LVL_DARK)) begin
            return '0;
        end
        return 7'(8'(LVL_DARK) - quot);
    endfunction

    // Lit time from period*duty: prod/100.
    function automatic t_phase_time on_from_prod(input logic [DUTY_PROD_W-1:0] prod);
        logic [38:0] scaled;
        scaled = 39'(prod) * 39'(DIV100_MUL);
        return PERIOD_W'(scaled >> DIV100_SHIFT);
    endfunction

endpackage

// ===== hdl/rlbt_if.sv =====
// Tick channel: one transfer per millisecond tick.
interface rlbt_in_if;
    logic valid;
    logic ready;
    logic start_req;
    logic stop_req;
    modport source (output valid, start_req, stop_req, input ready);
    modport sink   (input valid, start_req, stop_req, output ready);
endinterface

// Result channel: one transfer per tick.
interface rlbt_out_if;
    logic                   valid;
    logic                   ready;
    logic [rlbt_pkg::LVL_W-1:0] level_green;
    logic [rlbt_pkg::LVL_W-1:0] level_red;
    logic [rlbt_pkg::LVL_W-1:0] level_blue;
    logic                   pwm_enable;
    logic                   busy_res;
    logic                   status_led_n;
    logic                   sleep_req;
    modport source (output valid, level_green, level_red, level_blue, pwm_enable,
                    busy_res, status_led_n, sleep_req, input ready);
    modport sink   (input valid, level_green, level_red, level_blue, pwm_enable,
                    busy_res, status_led_n, sleep_req, output ready);
endinterface

// Register write channel.
interface rlbt_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [rlbt_pkg::CFG_IDX_W-1:0]   index;
    logic [rlbt_pkg::CFG_DATA_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/rgb_led_blink_timer_unit.sv =====
// RGB LED blink timer. Each transfer on the tick channel is one millisecond;
// a stop request ends a run and disables the PWM outputs, a start request
// latches the mode and arms a run that ends by itself after latency_s seconds.
// In blink mode the block alternates a lit phase (levels from color and
// brightness) and a dark phase (all levels 100, active low). The block takes
// one tick per clock unless settling or stalled at the output: a tick waits
// in the input register and its result is written to the output register as
// it advances, while the next tick is taken in. After reset and after every
// register write the tick path holds while the registered color-level and
// lit-time products settle; the register channel is always ready.
module rgb_led_blink_timer_unit #(
    parameter int TIME_WIDTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rlbt_in_if.sink      i_in,
    rlbt_cfg_if.sink     i_cfg,
    rlbt_out_if.source   o_out
);

    // Configuration registers.
    logic [rlbt_pkg::BRIGHT_W-1:0]  r_brightness;
    logic [rlbt_pkg::COLOR_W-1:0]   r_color;
    logic [rlbt_pkg::MODE_W-1:0]    r_blink_mode;
    logic [rlbt_pkg::PERIOD_W-1:0]  r_period;
    logic [rlbt_pkg::DUTY_W-1:0]    r_duty;
    logic [rlbt_pkg::LATENCY_W-1:0] r_latency;
    logic [1:0]                     r_settle;

    // Derived values.
    logic [2:0][rlbt_pkg::COLOR_PROD_W-1:0] r_color_prod;
    logic [rlbt_pkg::DUTY_PROD_W-1:0]       r_duty_prod;
    rlbt_pkg::t_levels                      r_lvl_cfg;
    rlbt_pkg::t_phase_time                  r_on_cfg;
    logic [rlbt_pkg::DUTY_W-1:0]            duty_clamped;

    // Input register.
    logic r_in_valid;
    logic r_in_start;
    logic r_in_stop;
    logic advance;

    // Timer state.
    logic [TIME_WIDTH-1:0]       r_now_ms, n_now_ms;
    logic [rlbt_pkg::MS_W-1:0]   r_ms_in_s, n_ms_in_s;
    logic [TIME_WIDTH-1:0]       r_now_s, n_now_s;
    logic                        r_running, n_running;
    logic [rlbt_pkg::MODE_W-1:0] r_mode, n_mode;
    logic                        r_phase_idx, n_phase_idx;
    logic                        r_phase_armed, n_phase_armed;
    logic [TIME_WIDTH-1:0]       r_deadline, n_deadline;
    logic [TIME_WIDTH-1:0]       r_stop_sec, n_stop_sec;
    rlbt_pkg::t_levels           r_on_lvl, n_on_lvl;
    rlbt_pkg::t_levels           r_drive, n_drive;
    rlbt_pkg::t_phase_time       r_on_time, n_on_time;
    rlbt_pkg::t_phase_time       r_off_time, n_off_time;
    logic                        r_outputs_on, n_outputs_on;
    logic                        lit;

    // Output register.
    logic              r_out_valid;
    rlbt_pkg::t_levels r_out_lvl;
    logic              r_out_pwm;
    logic              r_out_busy;
    logic              r_out_lit;

    // Register writes; each write restarts the settle count.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness <= rlbt_pkg::RST_BRIGHTNESS;
            r_color      <= rlbt_pkg::RST_COLOR;
            r_blink_mode <= rlbt_pkg::RST_MODE;
            r_period     <= rlbt_pkg::RST_PERIOD;
            r_duty       <= rlbt_pkg::RST_DUTY;
            r_latency    <= rlbt_pkg::RST_LATENCY;
            r_settle     <= rlbt_pkg::SETTLE_CYCLES;
        end else if (i_cfg.valid) begin
            r_settle <= rlbt_pkg::SETTLE_CYCLES;
            unique case (rlbt_pkg::t_cfg_idx'(i_cfg.index))
                rlbt_pkg::CFG_BRIGHTNESS: r_brightness <= i_cfg.data[rlbt_pkg::BRIGHT_W-1:0];
                rlbt_pkg::CFG_COLOR:      r_color      <= i_cfg.data[rlbt_pkg::COLOR_W-1:0];
                rlbt_pkg::CFG_MODE:       r_blink_mode <= i_cfg.data[rlbt_pkg::MODE_W-1:0];
                rlbt_pkg::CFG_PERIOD:     r_period     <= i_cfg.data[rlbt_pkg::PERIOD_W-1:0];
                rlbt_pkg::CFG_DUTY:       r_duty       <= i_cfg.data[rlbt_pkg::DUTY_W-1:0];
                rlbt_pkg::CFG_LATENCY:    r_latency    <= i_cfg.data[rlbt_pkg::LATENCY_W-1:0];
                default: ;
            endcase
        end else if (r_settle != 2'd0) begin
            r_settle <= r_settle - 2'd1;
        end
    end

    // Two-stage pipeline of lit levels and lit time from the registers.
    assign duty_clamped = (r_duty > rlbt_pkg::DUTY_FULL) ? rlbt_pkg::DUTY_FULL : r_duty;

    always_ff @(posedge i_clk) begin
        r_color_prod[0] <= 11'(r_color[7:4])  * 11'(r_brightness);
        r_color_prod[1] <= 11'(r_color[11:8]) * 11'(r_brightness);
        r_color_prod[2] <= 11'(r_color[3:0])  * 11'(r_brightness);
        r_duty_prod     <= 19'(r_period) * 19'(duty_clamped);
        for (int k = 0; k < 3; k++) begin
            r_lvl_cfg[k] <= rlbt_pkg::lvl_from_prod(r_color_prod[k]);
        end
        r_on_cfg <= rlbt_pkg::on_from_prod(r_duty_prod);
    end

    // A tick is processed when the derived values are settled and the
    // output register is free or being emptied.
    assign advance    = r_in_valid && (r_settle == 2'd0) && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_start <= i_in.start_req;
            r_in_stop  <= i_in.stop_req;
        end
    end

    // Next timer state for one tick: request, phase step, auto stop, time.
    always_comb begin
        n_now_ms      = r_now_ms + TIME_WIDTH'(1);
        n_ms_in_s     = r_ms_in_s + 10'd1;
        n_now_s       = r_now_s;
        n_running     = r_running;
        n_mode        = r_mode;
        n_phase_idx   = r_phase_idx;
        n_phase_armed = r_phase_armed;
        n_deadline    = r_deadline;
        n_stop_sec    = r_stop_sec;
        n_on_lvl      = r_on_lvl;
        n_drive       = r_drive;
        n_on_time     = r_on_time;
        n_off_time    = r_off_time;
        n_outputs_on  = r_outputs_on;

        // Stop has priority over start.
        if (r_in_stop) begin
            n_outputs_on  = 1'b0;
            n_running     = 1'b0;
            n_phase_idx   = 1'b0;
            n_phase_armed = 1'b0;
        end else if (r_in_start) begin
            n_stop_sec = r_now_s + TIME_WIDTH'(r_latency);
            n_mode     = r_blink_mode;
            n_running  = 1'b1;
            if (r_blink_mode == rlbt_pkg::MODE_BLINK) begin
                n_on_lvl      = r_lvl_cfg;
                n_on_time     = r_on_cfg;
                n_off_time    = r_period - r_on_cfg;
                n_phase_idx   = 1'b0;
                n_phase_armed = 1'b1;
                n_deadline    = r_now_ms + TIME_WIDTH'(r_on_cfg);
                n_drive       = r_lvl_cfg;
                n_outputs_on  = 1'b1;
            end
        end

        lit = n_running;

        // Phase sequencing while a run is active.
        if (n_running) begin
            if (n_mode == rlbt_pkg::MODE_BLINK) begin
                if (!n_phase_armed) begin
                    if (r_now_ms > n_deadline) begin
                        if (n_phase_idx) begin
                            n_deadline   = r_now_ms + TIME_WIDTH'(n_off_time);
                            n_drive      = rlbt_pkg::LEVELS_DARK;
                            n_outputs_on = 1'b1;
                            n_phase_idx  = 1'b0;
                        end else begin
                            n_phase_armed = 1'b1;
                            n_deadline    = r_now_ms + TIME_WIDTH'(n_on_time);
                            n_drive       = n_on_lvl;
                            n_outputs_on  = 1'b1;
                        end
                    end
                end else begin
                    n_phase_armed = 1'b0;
                    n_phase_idx   = !n_phase_idx;
                end
            end
            if (r_now_s > n_stop_sec) begin
                n_outputs_on  = 1'b0;
                n_running     = 1'b0;
                n_phase_idx   = 1'b0;
                n_phase_armed = 1'b0;
            end
        end

        // Second rollover.
        if (r_ms_in_s >= rlbt_pkg::MS_LAST) begin
            n_ms_in_s = '0;
            n_now_s   = r_now_s + TIME_WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now_ms      <= '0;
            r_ms_in_s     <= '0;
            r_now_s       <= '0;
            r_running     <= 1'b0;
            r_mode        <= '0;
            r_phase_idx   <= 1'b0;
            r_phase_armed <= 1'b0;
            r_deadline    <= '0;
            r_stop_sec    <= '0;
            r_on_lvl      <= rlbt_pkg::LEVELS_DARK;
            r_drive       <= rlbt_pkg::LEVELS_DARK;
            r_on_time     <= '0;
            r_off_time    <= '0;
            r_outputs_on  <= 1'b0;
        end else if (advance) begin
            r_now_ms      <= n_now_ms;
            r_ms_in_s     <= n_ms_in_s;
            r_now_s       <= n_now_s;
            r_running     <= n_running;
            r_mode        <= n_mode;
            r_phase_idx   <= n_phase_idx;
            r_phase_armed <= n_phase_armed;
            r_deadline    <= n_deadline;
            r_stop_sec    <= n_stop_sec;
            r_on_lvl      <= n_on_lvl;
            r_drive       <= n_drive;
            r_on_time     <= n_on_time;
            r_off_time    <= n_off_time;
            r_outputs_on  <= n_outputs_on;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_lvl  <= n_drive;
            r_out_pwm  <= n_outputs_on;
            r_out_busy <= n_running;
            r_out_lit  <= lit;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.level_green  = r_out_lvl[0];
    assign o_out.level_red    = r_out_lvl[1];
    assign o_out.level_blue   = r_out_lvl[2];
    assign o_out.pwm_enable   = r_out_pwm;
    assign o_out.busy_res     = r_out_busy;
    assign o_out.status_led_n = !r_out_lit;
    assign o_out.sleep_req    = !r_out_lit;

endmodule

// ===== hdl/rlbt_checker.sv =====
module rlbt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [6:0] i_level_green,
    input logic [6:0] i_level_red,
    input logic [6:0] i_level_blue,
    input logic       i_busy_res,
    input logic       i_status_led_n,
    input logic       i_sleep_req
);

    // No result is offered right after reset.
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

    // A stalled result keeps its levels.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_level_green)
            && $stable(i_level_red) && $stable(i_level_blue))
        else $error("stalled result changed");

    // Levels never exceed the dark level.
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_level_green <= 7'd100 && i_level_red <= 7'd100
            && i_level_blue <= 7'd100)
        else $error("level out of range");

    // Status LED and sleep request follow the same run check.
    a_status_sleep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_status_led_n == i_sleep_req)
        else $error("status LED and sleep request disagree");

    // A run still active after the tick was active at its check.
    a_busy_awake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_busy_res |-> !i_sleep_req)
        else $error("sleep requested while busy");

endmodule

bind rgb_led_blink_timer_unit rlbt_checker u_rlbt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_level_green  (o_out.level_green),
    .i_level_red    (o_out.level_red),
    .i_level_blue   (o_out.level_blue),
    .i_busy_res     (o_out.busy_res),
    .i_status_led_n (o_out.status_led_n),
    .i_sleep_req    (o_out.sleep_req)
);
